/* rtl/core/act_pkg.sv */
package act_pkg;

  // default table size and register reset values
  localparam int unsigned ENTRIES_DEF = 128;
  localparam logic [15:0] TIMEOUT_RST = 16'd15;

  // item kinds carried on in_tuser
  localparam logic [1:0] OP_LOOKUP = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_TICK   = 2'd2;

  // insert outcome codes
  localparam logic [1:0] STAT_NONE  = 2'd0;
  localparam logic [1:0] STAT_ADDED = 2'd1;
  localparam logic [1:0] STAT_DUP   = 2'd2;
  localparam logic [1:0] STAT_FULL  = 2'd3;

  // one tag word of the table: valid mark, address and insertion second
  typedef struct packed {
    logic        valid;
    logic [31:0] ip;
    logic [31:0] stamp;
  } tag_t;

  // write request from the sequencer to the table memories
  typedef struct packed {
    logic        tag_we;
    logic        mac_we;
    tag_t        tag;
    logic [47:0] mac;
  } mem_wr_t;

  // one result item
  typedef struct packed {
    logic [1:0]  status;
    logic [47:0] mac;
    logic        hit;
  } res_t;

endpackage

/* rtl/core/arp_cache_table.sv */
// channel  | ports             | content
// ---------+-------------------+-----------------------------------------------
// input    | in_t*  (tuser)    | [1:0] op
//          | in_t*  (tdata 80) | [31:0] ip_addr, [79:32] mac_addr
// result   | out_t* (tdata 56) | [0] hit, [48:1] mac_found, [50:49] insert_status
// config   | cfg_wr_*          | timeout_seconds (16 bits)
//
// Each item reads the tag/mac memories once per entry and compares each entry
// when its registered read returns; an insert then writes in S_WRITE. Op code
// 3 goes straight to the result, with no scan. After reset a clearing pass
// invalidates every tag; no item is taken until it ends. A stalled result sits
// in the output register while the next item is scanned.
module arp_cache_table
  import act_pkg::*;
#(
  parameter int unsigned ENTRIES = ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [1:0]  in_tuser,    // op
  input  logic [79:0] in_tdata,    // ip_addr, mac_addr
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,   // hit, mac_found, insert_status, zero fill
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);

  localparam int unsigned AW = $clog2(ENTRIES);

  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  tag_t          rd_tag;
  logic [47:0]   rd_mac;
  mem_wr_t       wr;
  logic          res_valid;
  logic          res_ready;
  res_t          res;
  res_t          out_res;

  // scan sequencer
  act_ctrl #(
    .ENTRIES (ENTRIES),
    .AW      (AW)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .item_valid  (in_tvalid),
    .item_ready  (in_tready),
    .item_op     (in_tuser),
    .item_ip     (in_tdata[31:0]),
    .item_mac    (in_tdata[79:32]),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .rd_addr     (rd_addr),
    .rd_tag      (rd_tag),
    .rd_mac      (rd_mac),
    .wr_addr     (wr_addr),
    .wr          (wr),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res)
  );

  // table memories
  act_store #(
    .ENTRIES (ENTRIES),
    .AW      (AW)
  ) u_store (
    .clk     (clk),
    .rd_addr (rd_addr),
    .rd_tag  (rd_tag),
    .rd_mac  (rd_mac),
    .wr_addr (wr_addr),
    .wr      (wr)
  );

  // result register
  act_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

  assign out_tdata = {5'd0, out_res.status, out_res.mac, out_res.hit};

endmodule

/* rtl/core/act_store.sv */
module act_store
  import act_pkg::*;
#(
  parameter int unsigned ENTRIES = ENTRIES_DEF,
  parameter int unsigned AW      = $clog2(ENTRIES)
) (
  input  logic          clk,
  input  logic [AW-1:0] rd_addr,
  output tag_t          rd_tag,
  output logic [47:0]   rd_mac,
  input  logic [AW-1:0] wr_addr,
  input  mem_wr_t       wr
);

  tag_t        tag_mem [ENTRIES];
  logic [47:0] mac_mem [ENTRIES];

  // tag memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr.tag_we) begin
      tag_mem[wr_addr] <= wr.tag;
    end
    rd_tag <= tag_mem[rd_addr];
  end

  // mac memory, addressed alongside the tags
  always_ff @(posedge clk) begin
    if (wr.mac_we) begin
      mac_mem[wr_addr] <= wr.mac;
    end
    rd_mac <= mac_mem[rd_addr];
  end

endmodule

/* rtl/core/act_ctrl.sv */
module act_ctrl
  import act_pkg::*;
#(
  parameter int unsigned ENTRIES = ENTRIES_DEF,
  parameter int unsigned AW      = $clog2(ENTRIES)
) (
  input  logic          clk,
  input  logic          rst_n,
  // item side
  input  logic          item_valid,
  output logic          item_ready,
  input  logic [1:0]    item_op,
  input  logic [31:0]   item_ip,
  input  logic [47:0]   item_mac,
  // timeout register
  input  logic          cfg_wr_en,
  input  logic [15:0]   cfg_wr_data,
  // table memories
  output logic [AW-1:0] rd_addr,
  input  tag_t          rd_tag,
  input  logic [47:0]   rd_mac,
  output logic [AW-1:0] wr_addr,
  output mem_wr_t       wr,
  // result side
  output logic          res_valid,
  input  logic          res_ready,
  output res_t          res
);

  localparam logic [AW-1:0] LAST = AW'(ENTRIES - 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_WRITE,
    S_DONE
  } state_t;

  state_t        state_r, state_nxt;
  logic [AW-1:0] addr_r, addr_nxt;
  logic [AW-1:0] cmp_addr_r, cmp_addr_nxt;
  logic [AW-1:0] free_addr_r, free_addr_nxt;
  logic          issuing_r, issuing_nxt;
  logic          pend_r, pend_nxt;
  logic          free_found_r, free_found_nxt;
  logic          dup_r, dup_nxt;
  logic [31:0]   now_r, now_nxt;
  logic [15:0]   timeout_r, timeout_nxt;
  logic [1:0]    op_r, op_nxt;
  logic [31:0]   ip_r, ip_nxt;
  logic [47:0]   mac_in_r, mac_in_nxt;
  logic          hit_r, hit_nxt;
  logic [47:0]   mac_r, mac_nxt;
  logic [1:0]    status_r, status_nxt;

  logic          tag_match;
  logic [31:0]   age;
  logic          expired;

  // compare of the entry read in the previous cycle
  assign tag_match = rd_tag.valid && (rd_tag.ip == ip_r);
  assign age       = now_r - rd_tag.stamp;
  assign expired   = rd_tag.valid && (age > {16'd0, timeout_r});

  assign rd_addr    = addr_r;
  assign item_ready = (state_r == S_IDLE);
  assign res_valid  = (state_r == S_DONE);
  assign res.hit    = hit_r;
  assign res.mac    = mac_r;
  assign res.status = status_r;

  // sequencer next state
  always_comb begin
    state_nxt      = state_r;
    addr_nxt       = addr_r;
    cmp_addr_nxt   = cmp_addr_r;
    free_addr_nxt  = free_addr_r;
    issuing_nxt    = issuing_r;
    pend_nxt       = pend_r;
    free_found_nxt = free_found_r;
    dup_nxt        = dup_r;
    now_nxt        = now_r;
    timeout_nxt    = cfg_wr_en ? cfg_wr_data : timeout_r;
    op_nxt         = op_r;
    ip_nxt         = ip_r;
    mac_in_nxt     = mac_in_r;
    hit_nxt        = hit_r;
    mac_nxt        = mac_r;
    status_nxt     = status_r;
    wr             = '0;
    wr_addr        = cmp_addr_r;

    case (state_r)
      // clearing pass over all tags after reset
      S_CLEAR: begin
        wr.tag_we = 1'b1;
        wr_addr   = addr_r;
        if (addr_r == LAST) begin
          addr_nxt  = '0;
          state_nxt = S_IDLE;
        end else begin
          addr_nxt = addr_r + 1'b1;
        end
      end

      // take an item and start the scan (op code 3 goes straight to S_DONE)
      S_IDLE: begin
        if (item_valid) begin
          op_nxt         = item_op;
          ip_nxt         = item_ip;
          mac_in_nxt     = item_mac;
          hit_nxt        = 1'b0;
          mac_nxt        = '0;
          status_nxt     = STAT_NONE;
          dup_nxt        = 1'b0;
          free_found_nxt = 1'b0;
          addr_nxt       = '0;
          issuing_nxt    = 1'b1;
          pend_nxt       = 1'b0;
          case (item_op)
            OP_LOOKUP: state_nxt = S_SCAN;
            OP_INSERT: state_nxt = S_SCAN;
            OP_TICK: begin
              now_nxt   = now_r + 32'd1;
              state_nxt = S_SCAN;
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end

      // read one entry a cycle, compare each entry when its registered read returns
      S_SCAN: begin
        pend_nxt     = issuing_r;
        cmp_addr_nxt = addr_r;
        if (issuing_r) begin
          if (addr_r == LAST) begin
            issuing_nxt = 1'b0;
          end else begin
            addr_nxt = addr_r + 1'b1;
          end
        end
        if (pend_r) begin
          case (op_r)
            OP_LOOKUP: begin
              if (tag_match) begin
                hit_nxt = 1'b1;
                mac_nxt = rd_mac;
              end
            end
            OP_INSERT: begin
              if (tag_match) begin
                dup_nxt = 1'b1;
              end
              if (!rd_tag.valid && !free_found_r) begin
                free_found_nxt = 1'b1;
                free_addr_nxt  = cmp_addr_r;
              end
            end
            OP_TICK: begin
              if (expired) begin
                wr.tag_we    = 1'b1;
                wr.tag       = rd_tag;
                wr.tag.valid = 1'b0;
              end
            end
            default: begin
            end
          endcase
          if (cmp_addr_r == LAST) begin
            addr_nxt  = '0;
            state_nxt = (op_r == OP_INSERT) ? S_WRITE : S_DONE;
          end
        end
      end

      // place an insert in the first free slot, or report a duplicate or a full table
      S_WRITE: begin
        wr_addr = free_addr_r;
        if (dup_r) begin
          status_nxt = STAT_DUP;
        end else if (free_found_r) begin
          wr.tag_we    = 1'b1;
          wr.mac_we    = 1'b1;
          wr.tag.valid = 1'b1;
          wr.tag.ip    = ip_r;
          wr.tag.stamp = now_r;
          wr.mac       = mac_in_r;
          status_nxt   = STAT_ADDED;
        end else begin
          status_nxt = STAT_FULL;
        end
        state_nxt = S_DONE;
      end

      // hold the result until the output stage takes it
      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      addr_r    <= '0;
      issuing_r <= 1'b0;
      pend_r    <= 1'b0;
      now_r     <= '0;
      timeout_r <= TIMEOUT_RST;
    end else begin
      state_r   <= state_nxt;
      addr_r    <= addr_nxt;
      issuing_r <= issuing_nxt;
      pend_r    <= pend_nxt;
      now_r     <= now_nxt;
      timeout_r <= timeout_nxt;
    end
    cmp_addr_r   <= cmp_addr_nxt;
    free_addr_r  <= free_addr_nxt;
    free_found_r <= free_found_nxt;
    dup_r        <= dup_nxt;
    op_r         <= op_nxt;
    ip_r         <= ip_nxt;
    mac_in_r     <= mac_in_nxt;
    hit_r        <= hit_nxt;
    mac_r        <= mac_nxt;
    status_r     <= status_nxt;
  end

endmodule

/* rtl/core/act_out.sv */
module act_out
  import act_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  res_valid,
  output logic  res_ready,
  input  res_t  res,
  output logic  out_valid,
  input  logic  out_ready,
  output res_t  out_res
);

  logic valid_r, valid_nxt;
  res_t data_r;

  assign res_ready = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_res   = data_r;

  // output register: refilled when empty or when its transfer completes
  always_comb begin
    valid_nxt = valid_r;
    if (res_ready) begin
      valid_nxt = res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    if (res_valid && res_ready) begin
      data_r <= res;
    end
  end

endmodule
